// ----- rtl/core/sng_pkg.sv -----
// Shared constants and types for the step noise generator.
`default_nettype none

package sng_pkg;

   // Phase fraction bits by default
   localparam int PHASE_FRAC_BITS_DEF = 32;

   // Field and register widths
   localparam int FREQ_W     = 24;
   localparam int LEVEL_W    = 31;
   localparam int HZ_SCALE_W = 41;
   localparam int SEED_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 41;

   // Multiplier split: low slice of hz_scale, rest goes to the high partial product
   localparam int HZ_SPLIT  = 21;
   localparam int PP_LO_W   = FREQ_W + HZ_SPLIT;
   localparam int PP_HI_W   = FREQ_W + HZ_SCALE_W - HZ_SPLIT;
   localparam int PROD_W    = 64;
   // step = product >> (SCALE_BASE - frac bits)
   localparam int SCALE_BASE = 48;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HZ_SCALE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_PHASE = 2'd2;

   // Reset values
   localparam logic [HZ_SCALE_W-1:0] HZ_SCALE_RST   = 41'd22906492;
   localparam logic [SEED_W-1:0]     SEED_RST       = 32'd404933;
   localparam logic                  FULL_PHASE_RST = 1'b1;

   // Generator constants
   localparam logic [SEED_W-1:0]  LCG_MUL      = 32'd435898247;
   localparam logic [SEED_W-1:0]  LCG_ADD      = 32'd382842987;
   localparam logic [LEVEL_W-1:0] LEVEL_OFFSET = 31'h4000_0000;

   // State loads from a configuration write
   typedef struct packed {
      logic              seed_load;
      logic [SEED_W-1:0] seed;
      logic              phase_load;
      logic              full_phase;
   } cfg_load_type;

endpackage

`default_nettype wire

// ----- rtl/core/sng_step_calc.sv -----
// Pipelined phase step: freq_q8 * hz_scale, scaled, floored and clipped to +/-1.0.
`default_nettype none

module sng_step_calc #(
   parameter int PHASE_FRAC_BITS = sng_pkg::PHASE_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output      logic                                in_ready,
   input  wire logic signed [sng_pkg::FREQ_W-1:0]   freq_q8,
   input  wire logic [sng_pkg::HZ_SCALE_W-1:0]      hz_scale,
   output      logic                                out_valid,
   input  wire logic                                out_ready,
   output      logic                                out_neg,
   output      logic signed [PHASE_FRAC_BITS+1:0]   out_step
);

   localparam int PW    = PHASE_FRAC_BITS + 2;
   localparam int SHIFT = sng_pkg::SCALE_BASE - PHASE_FRAC_BITS;
   localparam int QW    = sng_pkg::PROD_W - SHIFT;
   localparam logic [QW:0] Q_ONE = (QW+1)'(1) << PHASE_FRAC_BITS;
   localparam logic signed [PW-1:0] PHASE_ONE = {2'b01, {PHASE_FRAC_BITS{1'b0}}};

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic ld1, ld2, ld3, ld4;

   logic [sng_pkg::FREQ_W-1:0]  s1_mag_ff, s1_mag_in;
   logic                        s1_neg_ff;
   logic [sng_pkg::PP_LO_W-1:0] s2_pp_lo_ff, s2_pp_lo_in;
   logic [sng_pkg::PP_HI_W-1:0] s2_pp_hi_ff, s2_pp_hi_in;
   logic                        s2_neg_ff;
   logic [sng_pkg::PROD_W-1:0]  s3_prod_ff, s3_prod_in;
   logic                        s3_neg_ff;
   logic signed [PW-1:0]        s4_step_ff, s4_step_in;
   logic                        s4_neg_ff;

   logic [QW:0]              q_rnd;
   logic                     round_up;
   logic [PHASE_FRAC_BITS:0] q_clip;

   // a stage takes new data when empty or when its successor moves
   assign ld4 = !v4_ff || out_ready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign in_ready = ld1;

   assign v1_in = ld1 ? in_valid : v1_ff;
   assign v2_in = ld2 ? v1_ff : v2_ff;
   assign v3_in = ld3 ? v2_ff : v3_ff;
   assign v4_in = ld4 ? v3_ff : v4_ff;

   // stage 1: magnitude (most negative input gives 2^23, still fits unsigned)
   assign s1_mag_in = freq_q8[sng_pkg::FREQ_W-1] ? (~freq_q8 + 1'b1) : freq_q8;

   // stage 2: two partial products
   assign s2_pp_lo_in = sng_pkg::PP_LO_W'(s1_mag_ff)
                      * sng_pkg::PP_LO_W'(hz_scale[sng_pkg::HZ_SPLIT-1:0]);
   assign s2_pp_hi_in = sng_pkg::PP_HI_W'(s1_mag_ff)
                      * sng_pkg::PP_HI_W'(hz_scale[sng_pkg::HZ_SCALE_W-1:sng_pkg::HZ_SPLIT]);

   // stage 3: full product
   assign s3_prod_in = sng_pkg::PROD_W'(s2_pp_lo_ff)
                     + (sng_pkg::PROD_W'(s2_pp_hi_ff) << sng_pkg::HZ_SPLIT);

   // stage 4: shift, floor toward minus infinity for negatives, clip
   assign round_up   = s3_neg_ff && (|s3_prod_ff[SHIFT-1:0]);
   assign q_rnd      = {1'b0, s3_prod_ff[sng_pkg::PROD_W-1:SHIFT]} + (QW+1)'(round_up);
   assign q_clip     = (q_rnd > Q_ONE) ? Q_ONE[PHASE_FRAC_BITS:0] : q_rnd[PHASE_FRAC_BITS:0];
   assign s4_step_in = s3_neg_ff ? -$signed(PW'(q_clip)) : $signed(PW'(q_clip));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
      if (ld1) begin
         s1_mag_ff <= s1_mag_in;
         s1_neg_ff <= freq_q8[sng_pkg::FREQ_W-1];
      end
      if (ld2) begin
         s2_pp_lo_ff <= s2_pp_lo_in;
         s2_pp_hi_ff <= s2_pp_hi_in;
         s2_neg_ff   <= s1_neg_ff;
      end
      if (ld3) begin
         s3_prod_ff <= s3_prod_in;
         s3_neg_ff  <= s2_neg_ff;
      end
      if (ld4) begin
         s4_step_ff <= s4_step_in;
         s4_neg_ff  <= s3_neg_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_neg   = s4_neg_ff;
   assign out_step  = s4_step_ff;

   a_step_bounded: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (s4_step_ff <= PHASE_ONE) && (s4_step_ff >= -PHASE_ONE))
      else $error("phase step outside +/-1.0");

   a_step_sign: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !s4_neg_ff |-> !s4_step_ff[PW-1])
      else $error("non-negative frequency gave a negative step");

   a_step_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !out_ready |=> v4_ff && $stable(s4_step_ff) && $stable(s4_neg_ff))
      else $error("stalled step changed");

endmodule

`default_nettype wire

// ----- rtl/core/sng_state.sv -----
// Phase accumulator, trigger, LCG and held level; holds the result register.
`default_nettype none

module sng_state #(
   parameter int PHASE_FRAC_BITS = sng_pkg::PHASE_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sng_pkg::cfg_load_type               cfg,
   input  wire logic                                in_valid,
   output      logic                                in_ready,
   input  wire logic                                in_neg,
   input  wire logic signed [PHASE_FRAC_BITS+1:0]   in_step,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic signed [sng_pkg::LEVEL_W-1:0]  rsp_level
);

   localparam int PW = PHASE_FRAC_BITS + 2;
   localparam logic signed [PW-1:0] PHASE_ONE = {2'b01, {PHASE_FRAC_BITS{1'b0}}};

   logic signed [PW-1:0]             phase_ff, phase_in, phase_wrap;
   logic [sng_pkg::SEED_W-1:0]       lcg_ff, lcg_in;
   logic signed [sng_pkg::LEVEL_W-1:0] held_ff, held_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             in_fire, trig;

   assign in_ready = !rsp_valid_ff || !rsp_stall;
   assign in_fire  = in_valid && in_ready;

   assign trig = in_neg ? (phase_ff[PW-1] || (phase_ff == '0))
                        : (!phase_ff[PW-1] && (phase_ff >= PHASE_ONE));

   always_comb begin
      phase_wrap = phase_ff;
      if (trig) begin
         phase_wrap = in_neg ? (phase_ff + PHASE_ONE) : (phase_ff - PHASE_ONE);
      end
   end

   assign phase_in = phase_wrap + in_step;
   assign held_in  = trig ? $signed(lcg_ff[sng_pkg::LEVEL_W-1:0] - sng_pkg::LEVEL_OFFSET)
                          : held_ff;
   assign lcg_in   = lcg_ff * sng_pkg::LCG_MUL + sng_pkg::LCG_ADD;

   assign rsp_valid_in = in_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sng_pkg::FULL_PHASE_RST ? PHASE_ONE : '0;
         lcg_ff       <= sng_pkg::SEED_RST;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (in_fire) begin
            held_ff <= held_in;
         end
         if (cfg.phase_load) begin
            phase_ff <= cfg.full_phase ? PHASE_ONE : '0;
         end else if (in_fire) begin
            phase_ff <= phase_in;
         end
         if (cfg.seed_load) begin
            lcg_ff <= cfg.seed;
         end else if (in_fire) begin
            lcg_ff <= lcg_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = held_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff >= -PHASE_ONE)
      else $error("phase below -1.0");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      in_fire |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_lcg_only_on_item: assert property (@(posedge clock) disable iff (reset)
      !in_fire && !cfg.seed_load |=> $stable(lcg_ff))
      else $error("generator advanced without an item");

endmodule

`default_nettype wire

// ----- rtl/core/step_noise_generator_top.sv -----
// Top level of the step noise generator: config registers and pipeline wiring.
//
//   port group  direction  handshake           payload
//   req_        in         req_valid/req_stall req_freq_q8 (s24, Q16.8 Hz)
//   rsp_        out        rsp_valid/rsp_stall rsp_noise_level (s31, Q1.30)
//   csr_        in         csr_write_en        csr_index, csr_wdata
//
// One item per cycle while rsp_stall is low; rsp_valid follows the step stages.
// The rate is set by the phase/LCG update, which feeds back on itself for each item.
// Four step stages (magnitude, split multiply, sum, shift/clip) feed that update stage.
// Synchronous reset loads the register defaults and puts the phase at 1.0.
// rsp_stall holds the result register; the step stages keep filling behind it.
`default_nettype none

module step_noise_generator_top #(
   parameter int PHASE_FRAC_BITS = sng_pkg::PHASE_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic signed [sng_pkg::FREQ_W-1:0]    req_freq_q8,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic signed [sng_pkg::LEVEL_W-1:0]   rsp_noise_level,
   input  wire logic                                 csr_write_en,
   input  wire logic [sng_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [sng_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [sng_pkg::HZ_SCALE_W-1:0] hz_scale_ff;
   sng_pkg::cfg_load_type          cfg;
   logic                           req_ready;
   logic                           step_valid, step_ready, step_neg;
   logic signed [PHASE_FRAC_BITS+1:0] step_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         hz_scale_ff <= sng_pkg::HZ_SCALE_RST;
      end else if (csr_write_en && (csr_index == sng_pkg::CSR_HZ_SCALE)) begin
         hz_scale_ff <= csr_wdata[sng_pkg::HZ_SCALE_W-1:0];
      end
   end

   // seed and start phase act on the state directly when written
   always_comb begin
      cfg.seed_load  = csr_write_en && (csr_index == sng_pkg::CSR_SEED);
      cfg.seed       = csr_wdata[sng_pkg::SEED_W-1:0];
      cfg.phase_load = csr_write_en && (csr_index == sng_pkg::CSR_FULL_PHASE);
      cfg.full_phase = csr_wdata[0];
   end

   assign req_stall = !req_ready;

   sng_step_calc #(
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_step_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .freq_q8   (req_freq_q8),
      .hz_scale  (hz_scale_ff),
      .out_valid (step_valid),
      .out_ready (step_ready),
      .out_neg   (step_neg),
      .out_step  (step_val)
   );

   sng_state #(
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (step_valid),
      .in_ready  (step_ready),
      .in_neg    (step_neg),
      .in_step   (step_val),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_level (rsp_noise_level)
   );

endmodule

`default_nettype wire
